@@ src/cursor_shape_overlay_unit_macros.svh @@
// ---------------------------------------------------------------------------
// cursor shape overlay: assertion macros
// concurrent checks on the rising edge of clk, with and without reset gating
// ---------------------------------------------------------------------------
`ifndef CURSOR_SHAPE_OVERLAY_UNIT_MACROS_SVH
`define CURSOR_SHAPE_OVERLAY_UNIT_MACROS_SVH

// check gated off while rst is high
`define CSOV_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that also holds through reset
`define CSOV_CHECK_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/csov_pkg.sv @@
// ---------------------------------------------------------------------------
// csov_pkg
// types and constants shared by the cursor shape overlay modules
// ---------------------------------------------------------------------------
package csov_pkg;

  localparam int unsigned CfgDataW    = 13;
  localparam int unsigned MaxFrameDim = 4096;

  localparam logic [31:0] PixBlack = 32'hFF00_0000;
  localparam logic [31:0] PixWhite = 32'hFFFF_FFFF;
  localparam logic [31:0] RgbMask  = 32'h00FF_FFFF;
  localparam logic [7:0]  ChanMax  = 8'hFF;

  typedef enum logic [1:0] {
    CT_COLOR  = 2'd0,
    CT_MONO   = 2'd1,
    CT_MASKED = 2'd2,
    CT_NONE   = 2'd3
  } csov_ctype_e;

  typedef enum logic [2:0] {
    REG_CURSOR_TYPE   = 3'd0,
    REG_CURSOR_LEFT   = 3'd1,
    REG_CURSOR_TOP    = 3'd2,
    REG_CURSOR_WIDTH  = 3'd3,
    REG_CURSOR_HEIGHT = 3'd4,
    REG_SHAPE_PITCH   = 3'd5,
    REG_FRAME_WIDTH   = 3'd6,
    REG_FRAME_HEIGHT  = 3'd7
  } csov_reg_e;

  typedef struct packed {
    csov_ctype_e cursor_type;
    logic [12:0] cursor_left;
    logic [12:0] cursor_top;
    logic [6:0]  cursor_width;
    logic [7:0]  cursor_height;
    logic [8:0]  shape_pitch;
    logic [12:0] frame_width;
    logic [12:0] frame_height;
  } csov_cfg_t;

  typedef struct packed {
    logic        mode;
    logic [11:0] shape_address;
    logic [31:0] shape_word;
    logic [11:0] pixel_col;
    logic [11:0] pixel_row;
    logic [31:0] pixel_in;
  } csov_item_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] pixel;
    logic [1:0]  lane_a;
    logic [1:0]  lane_x;
    logic [2:0]  bitpos;
  } csov_tag_t;

endpackage

@@ src/csov_locate.sv @@
// ---------------------------------------------------------------------------
// csov_locate
// cursor rectangle test and shape memory addressing, in registered stages
// ---------------------------------------------------------------------------
module csov_locate import csov_pkg::*; #(
  parameter int SHAPE_WORDS = 4096
) (
  input  logic                           clk,
  input  logic                           adv,
  input  csov_cfg_t                      cfg,
  input  csov_item_t                     item,
  output logic [$clog2(SHAPE_WORDS)-1:0] rd_addr_a,
  output logic [$clog2(SHAPE_WORDS)-1:0] rd_addr_x,
  output logic [$clog2(SHAPE_WORDS)-1:0] ld_addr,
  output logic [31:0]                    ld_word,
  output csov_tag_t                      tag3
);

  localparam int AW = $clog2(SHAPE_WORDS);

  logic [7:0]         rows;
  logic signed [13:0] cx;
  logic signed [13:0] cy;
  logic               in_frame;
  logic               in_rect;

  logic        hit2;
  logic [6:0]  ux2;
  logic [7:0]  uy2;
  logic [7:0]  rows2;
  logic [31:0] pixel2;
  logic [11:0] addr2;
  logic [31:0] word2;

  logic [8:0]  row_x;
  logic [16:0] prod_a3;
  logic [17:0] prod_x3;
  logic        hit3;
  logic [6:0]  ux3;
  logic [31:0] pixel3;
  logic [11:0] addr3;
  logic [31:0] word3;

  logic [17:0] off_a;
  logic [17:0] off_x;

  // stage 1: cursor relative position and rectangle test
  always_comb begin
    rows = (cfg.cursor_type == CT_MONO) ? {1'b0, cfg.cursor_height[7:1]} : cfg.cursor_height;
    cx = $signed({2'b00, item.pixel_col}) - $signed({cfg.cursor_left[12], cfg.cursor_left});
    cy = $signed({2'b00, item.pixel_row}) - $signed({cfg.cursor_top[12], cfg.cursor_top});
    in_frame = ({1'b0, item.pixel_col} < cfg.frame_width)
            && ({1'b0, item.pixel_row} < cfg.frame_height)
            && (32'(item.pixel_col) < MaxFrameDim)
            && (32'(item.pixel_row) < MaxFrameDim);
    in_rect = !cx[13] && (cx[12:0] < {6'd0, cfg.cursor_width})
           && !cy[13] && (cy[12:0] < {5'd0, rows});
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit2   <= (cfg.cursor_type != CT_NONE) && in_frame && in_rect;
      ux2    <= cx[6:0];
      uy2    <= cy[7:0];
      rows2  <= rows;
      pixel2 <= item.pixel_in;
      addr2  <= item.shape_address;
      word2  <= item.shape_word;
    end
  end

  // stage 2: row offsets into the shape
  assign row_x = {1'b0, rows2} + {1'b0, uy2};

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_a3 <= {9'd0, uy2} * {8'd0, cfg.shape_pitch};
      prod_x3 <= {9'd0, row_x} * {9'd0, cfg.shape_pitch};
      hit3    <= hit2;
      ux3     <= ux2;
      pixel3  <= pixel2;
      addr3   <= addr2;
      word3   <= word2;
    end
  end

  // stage 3: byte offsets and word addresses
  always_comb begin
    if (cfg.cursor_type == CT_MONO) begin
      off_a = {1'b0, prod_a3} + {14'd0, ux3[6:3]};
    end else begin
      off_a = {1'b0, prod_a3} + {9'd0, ux3, 2'b00};
    end
    off_x = prod_x3 + {14'd0, ux3[6:3]};
  end

  // word count is a power of two, so the address wraps by truncation
  assign rd_addr_a = AW'(off_a[17:2]);
  assign rd_addr_x = AW'(off_x[17:2]);
  assign ld_addr   = AW'(addr3);
  assign ld_word   = word3;

  assign tag3.hit    = hit3;
  assign tag3.pixel  = pixel3;
  assign tag3.lane_a = off_a[1:0];
  assign tag3.lane_x = off_x[1:0];
  assign tag3.bitpos = ~ux3[2:0];

endmodule

@@ src/csov_shape_mem.sv @@
// ---------------------------------------------------------------------------
// csov_shape_mem
// shape word store, one write port and two registered read ports
// ---------------------------------------------------------------------------
module csov_shape_mem import csov_pkg::*; #(
  parameter int SHAPE_WORDS = 4096
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic                           we,
  input  logic [$clog2(SHAPE_WORDS)-1:0] waddr,
  input  logic [31:0]                    wdata,
  input  logic [$clog2(SHAPE_WORDS)-1:0] raddr_a,
  input  logic [$clog2(SHAPE_WORDS)-1:0] raddr_x,
  output logic [31:0]                    rdata_a,
  output logic [31:0]                    rdata_x
);

  logic [31:0] mem [SHAPE_WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rdata_a <= mem[raddr_a];
      rdata_x <= mem[raddr_x];
    end
  end

endmodule

@@ src/csov_blend.sv @@
// ---------------------------------------------------------------------------
// csov_blend
// cursor type decode, alpha multiply and divide by 255, two register stages
// ---------------------------------------------------------------------------
module csov_blend import csov_pkg::*; (
  input  logic        clk,
  input  logic        adv,
  input  csov_cfg_t   cfg,
  input  csov_tag_t   tag3,
  input  logic [31:0] rdata_a,
  input  logic [31:0] rdata_x,
  output logic [31:0] res_pixel,
  output logic        res_hit
);

  function automatic logic [7:0] lane_byte(input logic [31:0] w, input logic [1:0] lane);
    logic [7:0] b;
    case (lane)
      2'd0:    b = w[7:0];
      2'd1:    b = w[15:8];
      2'd2:    b = w[23:16];
      default: b = w[31:24];
    endcase
    return b;
  endfunction

  // exact x/255 for x up to 255*255
  function automatic logic [7:0] div255(input logic [16:0] x);
    logic [16:0] q;
    q = x + {8'd0, x[16:8]} + 17'd1;
    return q[15:8];
  endfunction

  csov_tag_t   tag4;
  logic [7:0]  byte_a;
  logic [7:0]  byte_x;
  logic        and_bit;
  logic        xor_bit;
  logic [7:0]  alpha;
  logic [7:0]  inv_alpha;
  logic [31:0] shape_rgb;
  logic [31:0] direct;
  logic        use_blend;

  logic [15:0] ps5 [3];
  logic [15:0] pd5 [3];
  logic [31:0] direct5;
  logic        use_blend5;
  logic        hit5;
  logic [7:0]  chan [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      tag4 <= tag3;
    end
  end

  // stage 4: shape decode
  always_comb begin
    byte_a    = lane_byte(rdata_a, tag4.lane_a);
    byte_x    = lane_byte(rdata_x, tag4.lane_x);
    and_bit   = byte_a[tag4.bitpos];
    xor_bit   = byte_x[tag4.bitpos];
    alpha     = rdata_a[31:24];
    inv_alpha = ChanMax - alpha;
    shape_rgb = rdata_a & RgbMask;
    direct    = tag4.pixel;
    use_blend = 1'b0;
    if (tag4.hit) begin
      case (cfg.cursor_type)
        CT_MONO: begin
          case ({and_bit, xor_bit})
            2'b00:   direct = PixBlack;
            2'b01:   direct = PixWhite;
            2'b10:   direct = tag4.pixel;
            default: direct = tag4.pixel ^ RgbMask;
          endcase
        end
        CT_COLOR: begin
          if (alpha == ChanMax) begin
            direct = PixBlack | shape_rgb;
          end else if (alpha != 8'd0) begin
            use_blend = 1'b1;
          end
        end
        CT_MASKED: begin
          if (alpha == 8'd0) begin
            direct = PixBlack | shape_rgb;
          end else begin
            direct = tag4.pixel ^ shape_rgb;
          end
        end
        default: direct = tag4.pixel;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        ps5[c] <= {8'd0, rdata_a[8*c +: 8]} * {8'd0, alpha};
        pd5[c] <= {8'd0, tag4.pixel[8*c +: 8]} * {8'd0, inv_alpha};
      end
      direct5    <= direct;
      use_blend5 <= use_blend;
      hit5       <= tag4.hit;
    end
  end

  // stage 5: sum and divide
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      chan[c] = div255({1'b0, ps5[c]} + {1'b0, pd5[c]});
    end
  end

  assign res_pixel = use_blend5 ? (PixBlack | {8'd0, chan[2], chan[1], chan[0]}) : direct5;
  assign res_hit   = hit5;

endmodule

@@ src/cursor_shape_overlay_unit.sv @@
// ---------------------------------------------------------------------------
// cursor_shape_overlay_unit
// pointer shape overlay on a BGRA pixel stream, with shape memory load path
// ---------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  in       sink       in_valid / in_ready   mode, shape_address, shape_word,
//                                            pixel_col, pixel_row, pixel_in
//  out      source     out_valid / out_ready pixel_out, cursor_hit
//  cfg      sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
//  one beat per clock while out_ready does not stall the pipe; a pixel beat gives
//  one result, a load beat writes the shape memory and gives no result
//  the rate is set by the two read ports of the shape memory, which serve the
//  monochrome AND and XOR planes in the same cycle
//  rst clears the pipeline valids and the configuration registers; shape memory is not cleared
//  out_ready low while a result waits freezes the whole pipeline and drops in_ready at once
//  SHAPE_WORDS must be a power of two
// ---------------------------------------------------------------------------
`include "cursor_shape_overlay_unit_macros.svh"

module cursor_shape_overlay_unit import csov_pkg::*; #(
  parameter int SHAPE_WORDS = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                mode,
  input  logic [11:0]         shape_address,
  input  logic [31:0]         shape_word,
  input  logic [11:0]         pixel_col,
  input  logic [11:0]         pixel_row,
  input  logic [31:0]         pixel_in,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         pixel_out,
  output logic                cursor_hit,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  localparam int AW = $clog2(SHAPE_WORDS);

  csov_cfg_t   cfg;
  csov_item_t  item1;
  logic [5:1]  stage_valid;
  logic [5:1]  stage_pix;
  logic        adv;
  logic        mem_we;

  logic [AW-1:0] rd_addr_a;
  logic [AW-1:0] rd_addr_x;
  logic [AW-1:0] ld_addr;
  logic [31:0]   ld_word;
  csov_tag_t     tag3;
  logic [31:0]   rdata_a;
  logic [31:0]   rdata_x;
  logic [31:0]   res_pixel;
  logic          res_hit;

  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;
  assign mem_we    = adv && stage_valid[3] && !stage_pix[3];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cursor_type   <= CT_NONE;
      cfg.cursor_left   <= '0;
      cfg.cursor_top    <= '0;
      cfg.cursor_width  <= '0;
      cfg.cursor_height <= '0;
      cfg.shape_pitch   <= '0;
      cfg.frame_width   <= '0;
      cfg.frame_height  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CURSOR_TYPE:   cfg.cursor_type   <= csov_ctype_e'(cfg_data[1:0]);
        REG_CURSOR_LEFT:   cfg.cursor_left   <= cfg_data[12:0];
        REG_CURSOR_TOP:    cfg.cursor_top    <= cfg_data[12:0];
        REG_CURSOR_WIDTH:  cfg.cursor_width  <= cfg_data[6:0];
        REG_CURSOR_HEIGHT: cfg.cursor_height <= cfg_data[7:0];
        REG_SHAPE_PITCH:   cfg.shape_pitch   <= cfg_data[8:0];
        REG_FRAME_WIDTH:   cfg.frame_width   <= cfg_data[12:0];
        REG_FRAME_HEIGHT:  cfg.frame_height  <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (adv) begin
      item1.mode          <= mode;
      item1.shape_address <= shape_address;
      item1.shape_word    <= shape_word;
      item1.pixel_col     <= pixel_col;
      item1.pixel_row     <= pixel_row;
      item1.pixel_in      <= pixel_in;
    end
  end

  // beat tracking along the pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
      stage_pix   <= '0;
      out_valid   <= 1'b0;
    end else if (adv) begin
      stage_valid <= {stage_valid[4:1], in_valid};
      stage_pix   <= {stage_pix[4:1], mode};
      out_valid   <= stage_valid[5] && stage_pix[5];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (adv) begin
      pixel_out  <= res_pixel;
      cursor_hit <= res_hit;
    end
  end

  csov_locate #(
    .SHAPE_WORDS(SHAPE_WORDS)
  ) u_locate (
    .clk       (clk),
    .adv       (adv),
    .cfg       (cfg),
    .item      (item1),
    .rd_addr_a (rd_addr_a),
    .rd_addr_x (rd_addr_x),
    .ld_addr   (ld_addr),
    .ld_word   (ld_word),
    .tag3      (tag3)
  );

  csov_shape_mem #(
    .SHAPE_WORDS(SHAPE_WORDS)
  ) u_shape_mem (
    .clk     (clk),
    .en      (adv),
    .we      (mem_we),
    .waddr   (ld_addr),
    .wdata   (ld_word),
    .raddr_a (rd_addr_a),
    .raddr_x (rd_addr_x),
    .rdata_a (rdata_a),
    .rdata_x (rdata_x)
  );

  csov_blend u_blend (
    .clk       (clk),
    .adv       (adv),
    .cfg       (cfg),
    .tag3      (tag3),
    .rdata_a   (rdata_a),
    .rdata_x   (rdata_x),
    .res_pixel (res_pixel),
    .res_hit   (res_hit)
  );

  `CSOV_CHECK_RST(a_reset_clears, rst |=> !out_valid && (stage_valid == '0), "pipe not empty after reset")
  `CSOV_CHECK(a_stall_holds, !adv |=> $stable(stage_valid) && $stable(stage_pix), "pipe moved in stall")
  `CSOV_CHECK(a_load_silent, stage_valid[5] && !stage_pix[5] && adv |=> !out_valid, "load beat gave a result")
  `CSOV_CHECK(a_result_source, $rose(out_valid) |-> $past(stage_valid[5] && stage_pix[5]), "result without pixel beat")

endmodule

@@ sim/overlay_pixel_checker.sv @@
// ---------------------------------------------------------------------------
// overlay_pixel_checker
// watches the load, pixel, result and register channels of the cursor
// overlay, keeps its own shape memory and register copy, works out the
// overlaid pixel for every accepted pixel beat and compares it, field by
// field, with the oldest outstanding result beat
// ---------------------------------------------------------------------------
module overlay_pixel_checker import csov_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic                mode,
  input  logic [11:0]         shape_address,
  input  logic [31:0]         shape_word,
  input  logic [11:0]         pixel_col,
  input  logic [11:0]         pixel_row,
  input  logic [31:0]         pixel_in,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [31:0]         pixel_out,
  input  logic                cursor_hit,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output int                  mismatches,
  output int                  pending
);

  typedef struct packed {
    logic [31:0] pixel;
    logic        hit;
  } overlay_result_t;

  logic [31:0]     shape_copy [4096];
  csov_cfg_t       regs;
  overlay_result_t expected_pixels [$];
  overlay_result_t want;
  bit              bad;

  function automatic logic [7:0] shape_byte_at(input int off);
    logic [31:0] w;
    w = shape_copy[12'(off >> 2)];
    return w[8 * (off % 4) +: 8];
  endfunction

  function automatic overlay_result_t overlay_pixel(input logic [11:0] col,
                                                    input logic [11:0] row,
                                                    input logic [31:0] pix);
    overlay_result_t r;
    int fw, fh, rows, pitch, lx, ty, cx, cy, bitpos, k, sc, dc, av;
    logic [7:0] and_byte, xor_byte, alpha;
    logic [31:0] s;
    r.pixel = pix;
    r.hit = 1'b0;
    fw = (int'(regs.frame_width) > MaxFrameDim) ? MaxFrameDim : int'(regs.frame_width);
    fh = (int'(regs.frame_height) > MaxFrameDim) ? MaxFrameDim : int'(regs.frame_height);
    rows = (regs.cursor_type == CT_MONO) ? int'(regs.cursor_height) / 2
                                         : int'(regs.cursor_height);
    pitch = int'(regs.shape_pitch);
    lx = $signed(regs.cursor_left);
    ty = $signed(regs.cursor_top);
    cx = int'(col) - lx;
    cy = int'(row) - ty;
    if (regs.cursor_type == CT_NONE || int'(col) >= fw || int'(row) >= fh ||
        cx < 0 || cx >= int'(regs.cursor_width) || cy < 0 || cy >= rows)
      return r;
    r.hit = 1'b1;
    if (regs.cursor_type == CT_MONO) begin
      bitpos = 7 - cx % 8;
      and_byte = shape_byte_at(cy * pitch + cx / 8);
      xor_byte = shape_byte_at((rows + cy) * pitch + cx / 8);
      case ({and_byte[bitpos], xor_byte[bitpos]})
        2'b00: r.pixel = PixBlack;
        2'b01: r.pixel = PixWhite;
        2'b11: r.pixel = pix ^ RgbMask;
        default: ;
      endcase
    end else begin
      s = shape_copy[12'((cy * pitch + cx * 4) >> 2)];
      alpha = s[31:24];
      if (regs.cursor_type == CT_COLOR) begin
        if (alpha == ChanMax) begin
          r.pixel = {ChanMax, s[23:0]};
        end else if (alpha != 8'd0) begin
          av = int'(alpha);
          for (k = 0; k < 3; k++) begin
            sc = s[8 * k +: 8];
            dc = pix[8 * k +: 8];
            r.pixel[8 * k +: 8] = 8'((sc * av + dc * (255 - av)) / 255);
          end
          r.pixel[31:24] = ChanMax;
        end
      end else if (alpha == 8'd0) begin
        r.pixel = {ChanMax, s[23:0]};
      end else begin
        r.pixel = pix ^ (s & RgbMask);
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      regs = '0;
      regs.cursor_type = CT_NONE;
      expected_pixels.delete();
      mismatches <= 0;
      pending <= 0;
    end else begin
      bad = 1'b0;
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          $error("result beat with nothing outstanding: pixel_out %h cursor_hit %b",
                 pixel_out, cursor_hit);
          bad = 1'b1;
        end else begin
          want = expected_pixels.pop_front();
          if (pixel_out !== want.pixel) begin
            $error("pixel_out mismatch: expected %h actual %h", want.pixel, pixel_out);
            bad = 1'b1;
          end
          if (cursor_hit !== want.hit) begin
            $error("cursor_hit mismatch: expected %b actual %b", want.hit, cursor_hit);
            bad = 1'b1;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CURSOR_TYPE:   regs.cursor_type   = csov_ctype_e'(cfg_data[1:0]);
          REG_CURSOR_LEFT:   regs.cursor_left   = cfg_data;
          REG_CURSOR_TOP:    regs.cursor_top    = cfg_data;
          REG_CURSOR_WIDTH:  regs.cursor_width  = cfg_data[6:0];
          REG_CURSOR_HEIGHT: regs.cursor_height = cfg_data[7:0];
          REG_SHAPE_PITCH:   regs.shape_pitch   = cfg_data[8:0];
          REG_FRAME_WIDTH:   regs.frame_width   = cfg_data;
          REG_FRAME_HEIGHT:  regs.frame_height  = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (mode == 1'b0) shape_copy[shape_address] = shape_word;
        else expected_pixels.push_back(overlay_pixel(pixel_col, pixel_row, pixel_in));
      end
      if (bad) mismatches <= mismatches + 1;
      pending <= expected_pixels.size();
    end
  end

endmodule

@@ sim/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top
// fills the low shape words that every cursor setting reads, runs a directed
// pass over the colour, monochrome and masked cursor types and the edge
// positions, then random register settings with mostly on-cursor pixel beats,
// random idling on the input side and random stalls on the result side; the
// checker beside the block predicts and compares every result beat
// ---------------------------------------------------------------------------
module tb_top import csov_pkg::*; ();

  localparam int WatchdogLimit = 2000;
  localparam int ShapeFill     = 512;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                mode = 1'b0;
  logic [11:0]         shape_address = '0;
  logic [31:0]         shape_word = '0;
  logic [11:0]         pixel_col = '0;
  logic [11:0]         pixel_row = '0;
  logic [31:0]         pixel_in = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [31:0]         pixel_out;
  logic                cursor_hit;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [2:0]          cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  int mismatches;
  int pending;
  int stalled_cycles = 0;
  bit sender_calm = 1'b0;
  bit reader_calm = 1'b0;
  int tgt_left, tgt_top, tgt_width, tgt_rows;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  cursor_shape_overlay_unit #(.SHAPE_WORDS(4096)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .mode(mode),
    .shape_address(shape_address), .shape_word(shape_word),
    .pixel_col(pixel_col), .pixel_row(pixel_row), .pixel_in(pixel_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .pixel_out(pixel_out), .cursor_hit(cursor_hit),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  overlay_pixel_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .mode(mode),
    .shape_address(shape_address), .shape_word(shape_word),
    .pixel_col(pixel_col), .pixel_row(pixel_row), .pixel_in(pixel_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .pixel_out(pixel_out), .cursor_hit(cursor_hit),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .pending(pending)
  );

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles >= WatchdogLimit) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  // result side: runs of ready broken by stalls, mostly short
  initial begin : result_reader
    forever begin
      out_ready <= 1'b1;
      repeat (1 + $urandom_range(0, reader_calm ? 200 : 12)) @(posedge clk);
      if (!reader_calm) begin
        out_ready <= 1'b0;
        repeat (($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3))
          @(posedge clk);
      end
    end
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] random_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 32'h0000_0000;
    if (r < 16) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  task automatic send_beat(input logic m, input logic [11:0] addr, input logic [31:0] word,
                           input logic [11:0] col, input logic [11:0] row,
                           input logic [31:0] pix);
    int gap;
    gap = sender_calm ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    shape_address <= addr;
    shape_word <= word;
    pixel_col <= col;
    pixel_row <= row;
    pixel_in <= pix;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_load(input logic [11:0] addr, input logic [31:0] word);
    send_beat(1'b0, addr, word, 12'($urandom), 12'($urandom), $urandom);
  endtask

  task automatic send_pixel(input logic [11:0] col, input logic [11:0] row,
                            input logic [31:0] pix);
    send_beat(1'b1, 12'($urandom), $urandom, col, row, pix);
  endtask

  // wait for every outstanding result, then let the pipe empty
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input csov_reg_e idx, input int val, input int w, input bit junk);
    logic [CfgDataW-1:0] d;
    d = 13'(val);
    if (w < 13) begin
      d = d & ((13'd1 << w) - 13'd1);
      if (junk) d = d | (13'($urandom) << w);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_cursor(input csov_ctype_e t, input int left, input int top,
                                input int width, input int height, input int pitch,
                                input int fw, input int fh);
    bit junk;
    junk = ($urandom_range(0, 3) == 0);
    write_reg(REG_CURSOR_TYPE, t, 2, junk);
    write_reg(REG_CURSOR_LEFT, left, 13, junk);
    write_reg(REG_CURSOR_TOP, top, 13, junk);
    write_reg(REG_CURSOR_WIDTH, width, 7, junk);
    write_reg(REG_CURSOR_HEIGHT, height, 8, junk);
    write_reg(REG_SHAPE_PITCH, pitch, 9, junk);
    write_reg(REG_FRAME_WIDTH, fw, 13, junk);
    write_reg(REG_FRAME_HEIGHT, fh, 13, junk);
    cfg_valid <= 1'b0;
    tgt_left = left;
    tgt_top = top;
    tgt_width = width;
    tgt_rows = (t == CT_MONO) ? height / 2 : height;
  endtask

  task automatic random_setting(input int p);
    csov_ctype_e t;
    int r, left, top, width, height, pitch, fw, fh;
    r = $urandom_range(0, 9);
    t = (r < 3) ? CT_COLOR : (r < 6) ? CT_MONO : (r < 9) ? CT_MASKED : CT_NONE;
    case (p)
      0: program_cursor(t, -4096, -4096, 127, 255, 511, 8191, 8191);
      1: program_cursor(t, 4095, 4095, 127, 255, 8, 4096, 4096);
      2: program_cursor(t, 0, 0, 0, 0, 0, 0, 0);
      default: begin
        left = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 8191)) - 4096
                                           : int'($urandom_range(0, 80)) - 40;
        top = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 8191)) - 4096
                                          : int'($urandom_range(0, 80)) - 40;
        width = ($urandom_range(0, 9) == 0) ? $urandom_range(65, 127) : $urandom_range(1, 64);
        height = ($urandom_range(0, 9) == 0) ? $urandom_range(129, 255)
                                             : $urandom_range(1, 128);
        pitch = ($urandom_range(0, 9) < 7) ? 4 * $urandom_range(1, 64) : $urandom_range(0, 511);
        // keep every shape read inside the filled words
        while (height > 1 && (height - 1) * pitch + 4 * width + 16 > 4 * ShapeFill)
          height = height / 2;
        r = $urandom_range(0, 9);
        fw = (r < 5) ? 4096 : (r < 7) ? $urandom_range(4097, 8191) : $urandom_range(1, 4095);
        r = $urandom_range(0, 9);
        fh = (r < 5) ? 4096 : (r < 7) ? $urandom_range(4097, 8191) : $urandom_range(1, 4095);
        program_cursor(t, left, top, width, height, pitch, fw, fh);
      end
    endcase
  endtask

  // mostly pixels on the cursor, some just off its edges, some anywhere, and some shape loads
  task automatic random_beat();
    int r, col, row;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      send_load(12'($urandom), random_word());
    end else begin
      if (r < 82 && tgt_width > 0 && tgt_rows > 0) begin
        col = tgt_left + int'($urandom_range(0, tgt_width - 1));
        row = tgt_top + int'($urandom_range(0, tgt_rows - 1));
      end else if (r < 91) begin
        col = ($urandom_range(0, 1) != 0) ? tgt_left - 1 : tgt_left + tgt_width;
        row = tgt_top + int'($urandom_range(0, tgt_rows + 1)) - 1;
      end else begin
        col = $urandom_range(0, 4095);
        row = $urandom_range(0, 4095);
      end
      if (col < 0 || col > 4095) col = $urandom_range(0, 4095);
      if (row < 0 || row > 4095) row = $urandom_range(0, 4095);
      send_pixel(12'(col), 12'(row), random_word());
    end
  endtask

  initial begin : stimulus
    int a, p, n;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // every shape entry the cursors can reach gets written before any is read
    for (a = 0; a < ShapeFill; a++) send_load(12'(a), random_word());

    // registers still at reset: no cursor
    settle();
    send_pixel(12'd0, 12'd0, 32'hFFFF_FFFF);
    send_pixel(12'd4095, 12'd4095, 32'h0000_0000);

    // colour: zero, full, half and minimal alpha, oversized frame
    settle();
    program_cursor(CT_COLOR, 0, 0, 4, 1, 16, 8191, 4096);
    send_load(12'd0, 32'h0011_2233);
    send_load(12'd1, 32'hFF44_5566);
    send_load(12'd2, 32'h80FF_00AA);
    send_load(12'd3, 32'h01FF_FFFF);
    send_pixel(12'd0, 12'd0, 32'h89AB_CDEF);
    send_pixel(12'd1, 12'd0, 32'h0000_0000);
    send_pixel(12'd2, 12'd0, 32'hFFFF_FFFF);
    send_pixel(12'd3, 12'd0, 32'h1234_5678);
    send_pixel(12'd4, 12'd0, 32'h1234_5678);

    // monochrome: invert, transparent, white, black
    settle();
    program_cursor(CT_MONO, 0, 0, 8, 4, 4, 4096, 4096);
    send_load(12'd0, 32'h0000_00CC);
    send_load(12'd2, 32'h0000_00AA);
    for (a = 0; a < 4; a++) send_pixel(12'(a), 12'd0, 32'h1234_5678);

    // masked colour at a negative position: copy, xor, beyond the frame
    settle();
    program_cursor(CT_MASKED, -2, -1, 4, 2, 16, 100, 4096);
    send_load(12'd6, 32'h00AB_CDEF);
    send_load(12'd7, 32'h7F0F_0F0F);
    send_pixel(12'd0, 12'd0, 32'h5566_7788);
    send_pixel(12'd1, 12'd0, 32'h5566_7788);
    send_pixel(12'd4095, 12'd0, 32'h5566_7788);

    for (p = 0; p < 14; p++) begin
      settle();
      sender_calm = ($urandom_range(0, 4) == 0);
      reader_calm = ($urandom_range(0, 4) == 0);
      random_setting(p);
      for (n = 0; n < 64; n++) random_beat();
    end

    settle();
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
